// ===== rtl/esc_pkg.sv =====
// package for the epoch seconds to calendar converter
// holds the reciprocal constants, calendar constants and the month start table
// no dependencies

package esc_pkg;

    // seconds in one day, split as 2^7 * 675 for the reciprocal divide
    localparam logic [16:0] SEC_PER_DAY  = 17'd86400;
    localparam int          DAY_PRESHIFT = 7;
    localparam logic [25:0] DAY_RECIP    = 26'd50903316;   // floor(2^35 / 675)
    localparam int          DAY_SHIFT    = 35;

    // days in one four-year cycle
    localparam logic [10:0] CYCLE_DAYS   = 11'd1461;
    localparam logic [15:0] CYCLE_RECIP  = 16'd45933;      // floor(2^26 / 1461)
    localparam int          CYCLE_SHIFT  = 26;

    // year boundaries inside a cycle, in days; the third year is the leap year
    localparam logic [10:0] YEAR1_START  = 11'd365;
    localparam logic [10:0] YEAR2_START  = 11'd730;
    localparam logic [10:0] YEAR3_START  = 11'd1096;

    // seconds in one hour, split as 2^4 * 225
    localparam logic [11:0] SEC_PER_HOUR = 12'd3600;
    localparam logic [12:0] HOUR_RECIP   = 13'd4660;       // floor(2^20 / 225)
    localparam int          HOUR_SHIFT   = 20;

    // seconds in one minute, split as 2^2 * 15
    localparam logic [5:0]  SEC_PER_MIN  = 6'd60;
    localparam logic [10:0] MIN_RECIP    = 11'd1092;       // floor(2^14 / 15)
    localparam int          MIN_SHIFT    = 14;

    localparam logic [11:0] BASE_YEAR    = 12'd1970;
    localparam int          MONTHS       = 12;

    // result word
    typedef struct packed {
        logic [5:0]  second;
        logic [5:0]  minute;
        logic [4:0]  hour;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [11:0] year;
    } cal_t;

    // first day of year (from 0) of a month, month index from 0
    function automatic logic [8:0] month_start(input logic [3:0] idx, input logic leap);
        logic [8:0] base;
        case (idx)
            4'd0:    base = 9'd0;
            4'd1:    base = 9'd31;
            4'd2:    base = 9'd59;
            4'd3:    base = 9'd90;
            4'd4:    base = 9'd120;
            4'd5:    base = 9'd151;
            4'd6:    base = 9'd181;
            4'd7:    base = 9'd212;
            4'd8:    base = 9'd243;
            4'd9:    base = 9'd273;
            4'd10:   base = 9'd304;
            4'd11:   base = 9'd334;
            default: base = 9'd0;
        endcase
        if (leap && (idx >= 4'd2))
        begin
            base = base + 9'd1;
        end
        return base;
    endfunction

endpackage

// ===== rtl/epoch_seconds_to_calendar.sv =====
// epoch seconds to calendar converter, top level
// turns a 32-bit seconds count into year, month, day, hour, minute and second
// depends on esc_pkg

// Converts seconds since 1970-01-01 00:00:00 into a calendar date and time of
// day, one word in and one word out. The pipeline is eight register stages
// deep, and a new word can be taken in every cycle while the output is not
// held back; the constant divides by 86400, 1461, 3600 and 60 are reciprocal
// multiplies, each followed by a one-step correction, and they set the stage
// count. Back-pressure on the output holds only the stages that are full, so
// gaps in the stream are squeezed out. Years follow a plain four-year leap
// rule, so 2100 counts as a leap year; the largest input lands in 2106.

module epoch_seconds_to_calendar
    import esc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // [31:0] epoch_seconds
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata     // [11:0] year, [15:12] month, [20:16] day,
                                    // [25:21] hour, [31:26] minute, [37:32] second,
                                    // [39:38] zero
);

    localparam int STAGES = 8;

    logic [STAGES-1:0] vld_reg;
    logic [STAGES-1:0] rdy;

    // stage 0: days estimate product
    logic [31:0] t0_reg;
    logic [50:0] pd0_reg;
    // stage 1: days estimate and its seconds
    logic [31:0] t1_reg;
    logic [15:0] q1_reg;
    logic [31:0] qm1_reg;
    // stage 2: corrected days and second of day
    logic [15:0] days2_reg;
    logic [16:0] sod2_reg;
    // stage 3: cycle and hour estimate products
    logic [15:0] days3_reg;
    logic [16:0] sod3_reg;
    logic [31:0] pc3_reg;
    logic [25:0] ph3_reg;
    // stage 4: cycle and hour estimates and their back products
    logic [15:0] days4_reg;
    logic [16:0] sod4_reg;
    logic [5:0]  cyc4_reg;
    logic [15:0] cm4_reg;
    logic [4:0]  hr4_reg;
    logic [16:0] hm4_reg;
    // stage 5: corrected cycle, day of cycle, hour, second of hour
    logic [5:0]  cyc5_reg;
    logic [10:0] dr5_reg;
    logic [4:0]  hr5_reg;
    logic [11:0] soh5_reg;
    // stage 6: year, day of year, minute estimate product
    logic [11:0] year6_reg;
    logic [8:0]  doy6_reg;
    logic        leap6_reg;
    logic [4:0]  hr6_reg;
    logic [11:0] soh6_reg;
    logic [20:0] pm6_reg;
    // stage 7: output word
    cal_t        out7_reg;

    // stage next values
    logic [50:0] pd0_next;
    logic [15:0] q1_next;
    logic [31:0] qm1_next;
    logic [31:0] r2_diff;
    logic [17:0] r2;
    logic [15:0] days2_next;
    logic [16:0] sod2_next;
    logic [31:0] pc3_next;
    logic [25:0] ph3_next;
    logic [5:0]  cyc4_next;
    logic [15:0] cm4_next;
    logic [4:0]  hr4_next;
    logic [16:0] hm4_next;
    logic [15:0] dr5_diff;
    logic [16:0] sr5_diff;
    logic [5:0]  cyc5_next;
    logic [10:0] dr5_next;
    logic [4:0]  hr5_next;
    logic [11:0] soh5_next;
    logic [1:0]  yoff6;
    logic [10:0] doy6_wide;
    logic [11:0] year6_next;
    logic        leap6_next;
    logic [20:0] pm6_next;
    logic [5:0]  min7_est;
    logic [11:0] ms7_diff;
    logic [6:0]  ms7;
    logic [3:0]  mi7;
    cal_t        out7_next;

    // ready ripples back from the output; a stage moves when it is empty or its successor moves
    always_comb
    begin
        rdy[STAGES-1] = !vld_reg[STAGES-1] || m_tready;
        for (int i = STAGES - 2; i >= 0; i--)
        begin
            rdy[i] = !vld_reg[i] || rdy[i+1];
        end
    end

    assign s_tready = rdy[0];
    assign m_tvalid = vld_reg[STAGES-1];
    assign m_tdata  = {2'b00, out7_reg};

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (rdy[0])
            begin
                vld_reg[0] <= s_tvalid;
            end
            for (int i = 1; i < STAGES; i++)
            begin
                if (rdy[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    // stage 0: (t / 128) * reciprocal of 675
    assign pd0_next = {26'd0, s_tdata[31:DAY_PRESHIFT]} * {25'd0, DAY_RECIP};

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            t0_reg  <= s_tdata;
            pd0_reg <= pd0_next;
        end
    end

    // stage 1: day estimate, never above the true count and at most one below
    assign q1_next  = pd0_reg[DAY_SHIFT+15:DAY_SHIFT];
    assign qm1_next = {16'd0, q1_next} * {15'd0, SEC_PER_DAY};

    always_ff @(posedge clk)
    begin
        if (rdy[1])
        begin
            t1_reg  <= t0_reg;
            q1_reg  <= q1_next;
            qm1_reg <= qm1_next;
        end
    end

    // stage 2: correct the day count, split off second of day
    assign r2_diff = t1_reg - qm1_reg;
    assign r2      = r2_diff[17:0];

    always_comb
    begin
        if (r2 >= {1'b0, SEC_PER_DAY})
        begin
            days2_next = q1_reg + 16'd1;
            sod2_next  = 17'(r2 - {1'b0, SEC_PER_DAY});
        end
        else
        begin
            days2_next = q1_reg;
            sod2_next  = r2[16:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[2])
        begin
            days2_reg <= days2_next;
            sod2_reg  <= sod2_next;
        end
    end

    // stage 3: reciprocal products for four-year cycle and hour
    assign pc3_next = {16'd0, days2_reg} * {16'd0, CYCLE_RECIP};
    assign ph3_next = {13'd0, sod2_reg[16:4]} * {13'd0, HOUR_RECIP};

    always_ff @(posedge clk)
    begin
        if (rdy[3])
        begin
            days3_reg <= days2_reg;
            sod3_reg  <= sod2_reg;
            pc3_reg   <= pc3_next;
            ph3_reg   <= ph3_next;
        end
    end

    // stage 4: estimates and their back products
    assign cyc4_next = pc3_reg[CYCLE_SHIFT+5:CYCLE_SHIFT];
    assign cm4_next  = {10'd0, cyc4_next} * {5'd0, CYCLE_DAYS};
    assign hr4_next  = ph3_reg[HOUR_SHIFT+4:HOUR_SHIFT];
    assign hm4_next  = {12'd0, hr4_next} * {5'd0, SEC_PER_HOUR};

    always_ff @(posedge clk)
    begin
        if (rdy[4])
        begin
            days4_reg <= days3_reg;
            sod4_reg  <= sod3_reg;
            cyc4_reg  <= cyc4_next;
            cm4_reg   <= cm4_next;
            hr4_reg   <= hr4_next;
            hm4_reg   <= hm4_next;
        end
    end

    // stage 5: correct cycle and hour
    assign dr5_diff = days4_reg - cm4_reg;
    assign sr5_diff = sod4_reg - hm4_reg;

    always_comb
    begin
        if (dr5_diff >= {5'd0, CYCLE_DAYS})
        begin
            cyc5_next = cyc4_reg + 6'd1;
            dr5_next  = 11'(dr5_diff - {5'd0, CYCLE_DAYS});
        end
        else
        begin
            cyc5_next = cyc4_reg;
            dr5_next  = dr5_diff[10:0];
        end
        if (sr5_diff >= {5'd0, SEC_PER_HOUR})
        begin
            hr5_next  = hr4_reg + 5'd1;
            soh5_next = 12'(sr5_diff - {5'd0, SEC_PER_HOUR});
        end
        else
        begin
            hr5_next  = hr4_reg;
            soh5_next = sr5_diff[11:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[5])
        begin
            cyc5_reg <= cyc5_next;
            dr5_reg  <= dr5_next;
            hr5_reg  <= hr5_next;
            soh5_reg <= soh5_next;
        end
    end

    // stage 6: year, day of year and leap flag within the cycle, minute estimate product
    always_comb
    begin
        leap6_next = 1'b0;
        if (dr5_reg < YEAR1_START)
        begin
            yoff6     = 2'd0;
            doy6_wide = dr5_reg;
        end
        else if (dr5_reg < YEAR2_START)
        begin
            yoff6     = 2'd1;
            doy6_wide = dr5_reg - YEAR1_START;
        end
        else if (dr5_reg < YEAR3_START)
        begin
            yoff6      = 2'd2;
            leap6_next = 1'b1;
            doy6_wide  = dr5_reg - YEAR2_START;
        end
        else
        begin
            yoff6     = 2'd3;
            doy6_wide = dr5_reg - YEAR3_START;
        end
    end

    assign year6_next = BASE_YEAR + {4'd0, cyc5_reg, 2'b00} + {10'd0, yoff6};
    assign pm6_next   = {11'd0, soh5_reg[11:2]} * {10'd0, MIN_RECIP};

    always_ff @(posedge clk)
    begin
        if (rdy[6])
        begin
            year6_reg <= year6_next;
            doy6_reg  <= doy6_wide[8:0];
            leap6_reg <= leap6_next;
            hr6_reg   <= hr5_reg;
            soh6_reg  <= soh5_reg;
            pm6_reg   <= pm6_next;
        end
    end

    // stage 7: minute and second, month and day
    assign min7_est = pm6_reg[MIN_SHIFT+5:MIN_SHIFT];
    assign ms7_diff = soh6_reg - {min7_est, 6'd0} + {4'd0, min7_est, 2'b00};
    assign ms7      = ms7_diff[6:0];

    always_comb
    begin
        mi7 = 4'd0;
        for (int i = 1; i < MONTHS; i++)
        begin
            if (doy6_reg >= month_start(4'(i), leap6_reg))
            begin
                mi7 = 4'(i);
            end
        end
    end

    always_comb
    begin
        out7_next.year  = year6_reg;
        out7_next.hour  = hr6_reg;
        out7_next.month = mi7 + 4'd1;
        out7_next.day   = 5'(doy6_reg - month_start(mi7, leap6_reg) + 9'd1);
        if (ms7 >= {1'b0, SEC_PER_MIN})
        begin
            out7_next.minute = min7_est + 6'd1;
            out7_next.second = 6'(ms7 - {1'b0, SEC_PER_MIN});
        end
        else
        begin
            out7_next.minute = min7_est;
            out7_next.second = ms7[5:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[7])
        begin
            out7_reg <= out7_next;
        end
    end

endmodule
